// ===== rtl/bbd_pkg.sv =====
// Package for the Bayer bilinear demosaic block: field widths, size limits,
// register indexes and the color phase codes. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bbd_pkg;

    // Fixed field widths.
    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 1;

    // Frame size limits and register reset value.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MIN_SIZE       = 3;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'd1;

    // Color site at the window center.
    typedef enum logic [1:0] {
        PH_RED   = 2'd0,
        PH_GREEN_R = 2'd1,
        PH_GREEN_B = 2'd2,
        PH_BLUE  = 2'd3
    } t_phase;

endpackage

`default_nettype wire

// ===== rtl/bbd_line_mem.sv =====
// Two-line store held as one synchronous RAM word {upper, middle} per column.
// Registered read with write-to-read forwarding; uses bbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbd_line_mem #(
    parameter int DEPTH = bbd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]    i_rd_addr,
    input  wire logic                        i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]    i_wr_addr,
    input  wire logic [2*bbd_pkg::PIX_W-1:0] i_wr_data,
    output logic      [2*bbd_pkg::PIX_W-1:0] o_rd_data
);

    localparam int DW = 2 * bbd_pkg::PIX_W;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_q;
    logic [DW-1:0] r_fwd_data;
    logic          r_fwd;

    // RAM array: the read returns the word before a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // Remember when a read collided with a write to the same column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule

`default_nettype wire

// ===== rtl/bayer_bilinear_demosaic_unit.sv =====
// Top level of the streaming 3x3 bilinear Bayer demosaic.
// Depends on bbd_pkg and bbd_line_mem.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+--------------------------------------
//  config   | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//  raw in   | in        | i_valid / o_ready    | i_pixel, i_frame_start
//  rgb out  | out       | o_valid / i_ready    | o_out_row, o_out_column, o_red,
//           |           |                      | o_green, o_blue, o_last
//
// One raw sample is taken per cycle while o_ready is high. Each sample
// passes the line RAM read and the window stage, then waits in the output
// register, which sends one to four RGB transactions, one per cycle while
// i_ready is high; border pixels add the extra transactions.
// Reset clears counters, window and valids; the line RAM needs no clearing.
// A stall on the output holds the output register; the window stage still
// drains samples that produce no result, and input is taken while it is free.
`timescale 1ns / 1ps
`default_nettype none

module bayer_bilinear_demosaic_unit #(
    parameter int MAX_WIDTH  = bbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbd_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bbd_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [bbd_pkg::PIX_W-1:0]     i_pixel,
    input  wire logic                          i_frame_start,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [bbd_pkg::COORD_W-1:0]   o_out_row,
    output logic      [bbd_pkg::COORD_W-1:0]   o_out_column,
    output logic      [bbd_pkg::PIX_W-1:0]     o_red,
    output logic      [bbd_pkg::PIX_W-1:0]     o_green,
    output logic      [bbd_pkg::PIX_W-1:0]     o_blue,
    output logic                               o_last
);

    localparam int PW  = bbd_pkg::PIX_W;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WSW = $clog2(MAX_WIDTH + 1);
    localparam int HSW = $clog2(MAX_HEIGHT + 1);
    localparam int MSW = (WSW > HSW) ? WSW : HSW;
    localparam int SW  = ((MSW > bbd_pkg::CFG_W) ? MSW : bbd_pkg::CFG_W) + 1;

    // Configuration registers.
    logic [bbd_pkg::CFG_W-1:0] r_active_width;
    logic [bbd_pkg::CFG_W-1:0] r_active_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_width  <= bbd_pkg::CFG_RESET;
            r_active_height <= bbd_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bbd_pkg::REG_ACTIVE_WIDTH:  r_active_width  <= i_cfg_data;
                bbd_pkg::REG_ACTIVE_HEIGHT: r_active_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame sizes clamped to the supported range.
    logic [SW-1:0] w_size;
    logic [SW-1:0] h_size;
    logic [SW-1:0] cfg_w_ext;
    logic [SW-1:0] cfg_h_ext;

    always_comb begin
        cfg_w_ext = SW'(r_active_width);
        cfg_h_ext = SW'(r_active_height);
        if (cfg_w_ext < SW'(bbd_pkg::MIN_SIZE)) begin
            w_size = SW'(bbd_pkg::MIN_SIZE);
        end else if (cfg_w_ext > SW'(MAX_WIDTH)) begin
            w_size = SW'(MAX_WIDTH);
        end else begin
            w_size = cfg_w_ext;
        end
        if (cfg_h_ext < SW'(bbd_pkg::MIN_SIZE)) begin
            h_size = SW'(bbd_pkg::MIN_SIZE);
        end else if (cfg_h_ext > SW'(MAX_HEIGHT)) begin
            h_size = SW'(MAX_HEIGHT);
        end else begin
            h_size = cfg_h_ext;
        end
    end

    // Stage handshakes.
    logic accept;
    logic s1_fire;
    logic s1_emit;
    logic s2_free;
    logic out_fire;
    logic s2_last;

    assign accept   = i_valid && o_ready;
    assign out_fire = o_valid && i_ready;

    // Position counters: the current sample's position and the next one.
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [SW-1:0] col_cur;
    logic [SW-1:0] row_cur;
    logic [SW-1:0] col_nxt;
    logic [SW-1:0] row_nxt;

    always_comb begin
        col_cur = SW'(r_col);
        row_cur = SW'(r_row);
        if (i_frame_start) begin
            col_cur = '0;
            row_cur = '0;
        end
        if (col_cur >= w_size) begin
            col_cur = '0;
            row_cur = row_cur + SW'(1);
        end
        if (row_cur >= h_size) begin
            row_cur = '0;
        end
        col_nxt = col_cur + SW'(1);
        row_nxt = row_cur;
        if (col_nxt >= w_size) begin
            col_nxt = '0;
            row_nxt = row_cur + SW'(1);
            if (row_nxt >= h_size) begin
                row_nxt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= col_nxt[CW-1:0];
            r_row <= row_nxt[RW-1:0];
        end
    end

    // Stage 1 registers: sample waiting for its line RAM word.
    logic          r_s1_valid;
    logic [PW-1:0] r_s1_px;
    logic [CW-1:0] r_s1_c;
    logic [RW-1:0] r_s1_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px <= i_pixel;
            r_s1_c  <= col_cur[CW-1:0];
            r_s1_r  <= row_cur[RW-1:0];
        end
    end

    assign o_ready = !r_s1_valid || s1_fire;

    // Line RAM: read at accept, write back {middle, pixel} when stage 1 moves.
    logic [2*PW-1:0] line_rd;
    logic [PW-1:0]   upper_px;
    logic [PW-1:0]   middle_px;

    bbd_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (col_cur[CW-1:0]),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_c),
        .i_wr_data ({middle_px, r_s1_px}),
        .o_rd_data (line_rd)
    );

    assign upper_px  = line_rd[2*PW-1:PW];
    assign middle_px = line_rd[PW-1:0];

    // Window columns c-2 and c-1, top to bottom.
    logic [PW-1:0] r_wc0 [3];
    logic [PW-1:0] r_wc1 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int y = 0; y < 3; y++) begin
                r_wc0[y] <= '0;
                r_wc1[y] <= '0;
            end
        end else if (s1_fire) begin
            for (int y = 0; y < 3; y++) begin
                r_wc0[y] <= r_wc1[y];
            end
            r_wc1[0] <= upper_px;
            r_wc1[1] <= middle_px;
            r_wc1[2] <= r_s1_px;
        end
    end

    // Window center position and border flags.
    logic [RW-1:0] ctr_i;
    logic [CW-1:0] ctr_j;
    logic          row_lo;
    logic          row_hi;
    logic          col_lo;
    logic          col_hi;

    always_comb begin
        ctr_i   = r_s1_r - RW'(1);
        ctr_j   = r_s1_c - CW'(1);
        s1_emit = (r_s1_r >= RW'(2)) && (r_s1_c >= CW'(2));
        row_lo  = (ctr_i == RW'(1));
        row_hi  = (SW'(ctr_i) == h_size - SW'(2)) && (h_size > SW'(bbd_pkg::MIN_SIZE));
        col_lo  = (ctr_j == CW'(1));
        col_hi  = (SW'(ctr_j) == w_size - SW'(2)) && (w_size > SW'(bbd_pkg::MIN_SIZE));
    end

    assign s1_fire = r_s1_valid && (!s1_emit || s2_free);

    // Bilinear averages over the window; averages are truncated.
    logic [PW+1:0]   sum_cross;
    logic [PW+1:0]   sum_diag;
    logic [PW:0]     sum_horiz;
    logic [PW:0]     sum_vert;
    logic [PW-1:0]   avg_cross;
    logic [PW-1:0]   avg_diag;
    logic [PW-1:0]   avg_horiz;
    logic [PW-1:0]   avg_vert;
    logic [PW-1:0]   ctr_px;
    bbd_pkg::t_phase phase;
    logic [PW-1:0]   red_n;
    logic [PW-1:0]   green_n;
    logic [PW-1:0]   blue_n;

    always_comb begin
        sum_cross = (PW+2)'(r_wc1[0]) + (PW+2)'(r_wc0[1])
                  + (PW+2)'(middle_px) + (PW+2)'(r_wc1[2]);
        sum_diag  = (PW+2)'(r_wc0[0]) + (PW+2)'(upper_px)
                  + (PW+2)'(r_wc0[2]) + (PW+2)'(r_s1_px);
        sum_horiz = (PW+1)'(r_wc0[1]) + (PW+1)'(middle_px);
        sum_vert  = (PW+1)'(r_wc1[0]) + (PW+1)'(r_wc1[2]);
        avg_cross = sum_cross[PW+1:2];
        avg_diag  = sum_diag[PW+1:2];
        avg_horiz = sum_horiz[PW:1];
        avg_vert  = sum_vert[PW:1];
        ctr_px    = r_wc1[1];
        phase     = bbd_pkg::t_phase'({~ctr_i[0], ctr_j[0]});
    end

    // Pick the interpolation per color site.
    always_comb begin
        unique case (phase)
            bbd_pkg::PH_RED: begin
                red_n = ctr_px;    green_n = avg_cross; blue_n = avg_diag;
            end
            bbd_pkg::PH_BLUE: begin
                red_n = avg_diag;  green_n = avg_cross; blue_n = ctr_px;
            end
            bbd_pkg::PH_GREEN_R: begin
                red_n = avg_horiz; green_n = ctr_px;    blue_n = avg_vert;
            end
            default: begin
                red_n = avg_vert;  green_n = ctr_px;    blue_n = avg_horiz;
            end
        endcase
    end

    // Output register: one interior result plus its border copies.
    logic          r_s2_valid;
    logic [PW-1:0] r_red;
    logic [PW-1:0] r_green;
    logic [PW-1:0] r_blue;
    logic [RW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic          r_row_lo;
    logic          r_row_two;
    logic          r_col_lo;
    logic          r_col_two;
    logic          r_a;
    logic          r_b;

    assign s2_last = (r_a == r_row_two) && (r_b == r_col_two);
    assign s2_free = !r_s2_valid || (i_ready && s2_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_a        <= 1'b0;
            r_b        <= 1'b0;
        end else if (s1_fire && s1_emit) begin
            r_s2_valid <= 1'b1;
            r_a        <= 1'b0;
            r_b        <= 1'b0;
        end else if (out_fire) begin
            if (s2_last) begin
                r_s2_valid <= 1'b0;
            end else if (r_b == r_col_two) begin
                r_a <= 1'b1;
                r_b <= 1'b0;
            end else begin
                r_b <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_emit) begin
            r_red     <= red_n;
            r_green   <= green_n;
            r_blue    <= blue_n;
            r_i       <= ctr_i;
            r_j       <= ctr_j;
            r_row_lo  <= row_lo;
            r_row_two <= row_lo || row_hi;
            r_col_lo  <= col_lo;
            r_col_two <= col_lo || col_hi;
        end
    end

    // Coordinates of the current copy: low border, center, or high border.
    logic [RW-1:0] row_sel;
    logic [CW-1:0] col_sel;
    logic [RW-1:0] h_last;
    logic [CW-1:0] w_last;
    logic [31:0]   row_wide;
    logic [31:0]   col_wide;

    always_comb begin
        h_last = RW'(h_size - SW'(1));
        w_last = CW'(w_size - SW'(1));
        if (!r_a) begin
            row_sel = r_row_lo ? '0 : r_i;
        end else begin
            row_sel = r_row_lo ? r_i : h_last;
        end
        if (!r_b) begin
            col_sel = r_col_lo ? '0 : r_j;
        end else begin
            col_sel = r_col_lo ? r_j : w_last;
        end
        row_wide = 32'(row_sel);
        col_wide = 32'(col_sel);
    end

    assign o_valid      = r_s2_valid;
    assign o_out_row    = row_wide[bbd_pkg::COORD_W-1:0];
    assign o_out_column = col_wide[bbd_pkg::COORD_W-1:0];
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_last       = s2_last;

endmodule

`default_nettype wire
